### hw/rtl/udf_pkg.sv
// Shared types and constants for the unsigned decimal formatter.
package udf_pkg;

  // Twenty decimal digits cover the largest 64-bit value.
  localparam int DIGITS  = 20;
  localparam int DIG_W   = $clog2(DIGITS + 1);
  localparam int NORM_W  = $clog2(DIGITS);
  localparam int VALUE_W = 64;
  localparam int CNT_W   = $clog2(VALUE_W + 1);
  localparam int LEN_W   = 6;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Value size selector codes.
  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;
  localparam logic [1:0] SIZE_64 = 2'd3;

  // Operation applied to every digit cell in a cycle.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_DABBLE,
    OP_SHIFT,
    OP_CLEAR
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_NORM,
    S_EMIT
  } fmt_state_t;

  typedef enum logic [1:0] {
    E_IDLE,
    E_CALC,
    E_RUN
  } emit_state_t;

  // Field description handed to the emitter when the digits are ready.
  typedef struct packed {
    logic [DIG_W-1:0] ndig;
    logic [LEN_W-1:0] min_width;
    logic             has_prec;
    logic [LEN_W-1:0] prec;
    logic             zero_flag;
    logic             left_flag;
  } field_spec_t;

  // Emitter status seen by the controller.
  typedef struct packed {
    logic busy;
    logic done;
    logic dig_shift;
  } emit_status_t;

endpackage

### hw/rtl/udf_bcd_cell.sv
// One BCD digit cell of the double-dabble chain.
module udf_bcd_cell
  import udf_pkg::*;
(
  input  logic       clk,
  input  cell_op_t   op,
  input  logic       bit_in,
  input  logic [3:0] digit_in,
  output logic       bit_out,
  output logic [3:0] digit
);

  logic [3:0] digit_r;
  logic [3:0] digit_nxt;
  logic [3:0] adj;

  // Add three when the digit would overflow on the next doubling.
  assign adj     = (digit_r >= 4'd5) ? digit_r + 4'd3 : digit_r;
  assign bit_out = adj[3];
  assign digit   = digit_r;

  // Doubling takes the carry from the lower cell; a digit shift takes its digit.
  always_comb begin
    case (op)
      OP_DABBLE: digit_nxt = {adj[2:0], bit_in};
      OP_SHIFT:  digit_nxt = digit_in;
      OP_CLEAR:  digit_nxt = 4'd0;
      default:   digit_nxt = digit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

### hw/rtl/udf_field_emit.sv
// Field layout and character emitter with the output register.
module udf_field_emit
  import udf_pkg::*;
#(
  parameter int MAX_FIELD = 63
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  field_spec_t  spec,
  input  logic [3:0]   top_digit,
  output emit_status_t status,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [15:0]  out_tdata,   // [7:0] char_code, [13:8] total_length, [15:14] zero
  output logic         out_tlast    // last
);

  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_FIELD);

  emit_state_t state_r, state_nxt;

  logic [DIG_W-1:0] ndig_r;
  logic [LEN_W-1:0] zeros_r, width_r;
  logic             left_r;
  logic [7:0]       padch_r;
  logic [LEN_W-1:0] lead_end_r, zero_end_r, dig_end_r, len_r, pos_r;
  logic             out_valid_r;
  logic [7:0]       out_char_r;
  logic [LEN_W-1:0] out_len_r;
  logic             out_last_r;

  logic [LEN_W-1:0] zeros_nxt;
  logic [LEN_W-1:0] body, pad, lead_end, full, len_nxt;
  logic             slot_free, is_last, in_digits;
  logic [7:0]       char_nxt;
  logic             emit, done;

  // Precision zeros needed in front of the digits.
  always_comb begin
    if (spec.has_prec && (spec.prec > LEN_W'(spec.ndig))) begin
      zeros_nxt = spec.prec - LEN_W'(spec.ndig);
    end else begin
      zeros_nxt = '0;
    end
  end

  // Field layout: leading pad, zeros, digits, trailing pad.
  always_comb begin
    body     = LEN_W'(ndig_r) + zeros_r;
    pad      = (width_r > body) ? width_r - body : '0;
    lead_end = left_r ? '0 : pad;
    full     = pad + body;
    len_nxt  = (full > LEN_CAP) ? LEN_CAP : full;
  end

  // Character at the current position.
  always_comb begin
    slot_free = !out_valid_r || out_tready;
    is_last   = (pos_r == len_r - LEN_W'(1));
    in_digits = 1'b0;
    if (pos_r < lead_end_r) begin
      char_nxt = padch_r;
    end else if (pos_r < zero_end_r) begin
      char_nxt = CHAR_ZERO;
    end else if (pos_r < dig_end_r) begin
      char_nxt  = CHAR_ZERO + {4'd0, top_digit};
      in_digits = 1'b1;
    end else begin
      char_nxt = CHAR_SPACE;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      E_IDLE: begin
        if (start) state_nxt = E_CALC;
      end
      E_CALC: begin
        state_nxt = (len_nxt == '0) ? E_IDLE : E_RUN;
      end
      E_RUN: begin
        if (slot_free && is_last) state_nxt = E_IDLE;
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    emit = 1'b0;
    done = 1'b0;
    case (state_r)
      E_CALC: done = (len_nxt == '0);
      E_RUN: begin
        emit = slot_free;
        done = slot_free && is_last;
      end
      default: begin
        emit = 1'b0;
        done = 1'b0;
      end
    endcase
  end

  assign status.busy      = (state_r != E_IDLE);
  assign status.done      = done;
  assign status.dig_shift = emit && in_digits;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= E_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Layout and output payload registers.
  always_ff @(posedge clk) begin
    if (start && (state_r == E_IDLE)) begin
      ndig_r  <= spec.ndig;
      zeros_r <= zeros_nxt;
      width_r <= spec.min_width;
      left_r  <= spec.left_flag;
      padch_r <= (spec.zero_flag && !spec.has_prec) ? CHAR_ZERO : CHAR_SPACE;
    end
    if (state_r == E_CALC) begin
      lead_end_r <= lead_end;
      zero_end_r <= lead_end + zeros_r;
      dig_end_r  <= lead_end + body;
      len_r      <= len_nxt;
      pos_r      <= '0;
    end else if (emit) begin
      pos_r <= pos_r + LEN_W'(1);
    end
    if (emit) begin
      out_char_r <= char_nxt;
      out_last_r <= is_last;
      out_len_r  <= is_last ? len_r : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_len_r, out_char_r};
  assign out_tlast  = out_last_r;

  // The length rides only on the final beat.
  a_len_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[13:8] != 6'd0))
    else $error("final beat without a length");

  a_len_zero_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[13:8] == 6'd0))
    else $error("length on a non-final beat");

  // Emission never runs past the field.
  a_pos_in_field: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == E_RUN) |-> ((pos_r < len_r) && (len_r <= LEN_CAP)))
    else $error("position beyond the field");

endmodule

### hw/rtl/unsigned_decimal_formatter.sv
// Timing: the first character follows the conversion of the B = 8/16/32/64 value bits by size, then
// N = 0..19 leading-zero digit shifts through the top cell of the BCD chain.
// Throughput: a new item is accepted only after the last character of the previous one; L characters
// leave at one per cycle without stalls, and the double-dabble chain converts one value bit per cycle.
// Reset: synchronous active-low rst_n clears the controller, emitter and output valid.
// Digit cells hold no reset value; they are cleared whenever the block is idle.
module unsigned_decimal_formatter
  import udf_pkg::*;
#(
  parameter int MAX_FIELD = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // [63:0] value, [69:64] min_width, [70] has_precision,
                                  // [76:71] precision, [77] zero_flag, [78] left_flag
  input  logic [1:0]  in_tuser,   // [1:0] size_select
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] char_code, [13:8] total_length
  output logic        out_tlast   // last
);

  fmt_state_t state_r, state_nxt;

  logic [VALUE_W-1:0] val_r;
  logic [CNT_W-1:0]   bit_cnt_r;
  logic [NORM_W-1:0]  norm_cnt_r;
  logic               zero_val_r;
  logic [LEN_W-1:0]   width_r, prec_r;
  logic               has_prec_r, zero_r, left_r;

  logic [VALUE_W-1:0] val_load;
  logic [CNT_W-1:0]   cnt_load;
  logic               accept, norm_go, emit_start;
  cell_op_t           cell_op;
  field_spec_t        spec;
  emit_status_t       emit_st;

  logic [DIGITS:0] carry;
  logic [3:0]      dchain [DIGITS+1];

  assign accept = in_tvalid && in_tready;

  // Truncate and left-align the value so the chain sees its top bit first.
  always_comb begin
    case (in_tuser)
      SIZE_8: begin
        val_load = {in_tdata[7:0], 56'd0};
        cnt_load = CNT_W'(8);
      end
      SIZE_16: begin
        val_load = {in_tdata[15:0], 48'd0};
        cnt_load = CNT_W'(16);
      end
      SIZE_32: begin
        val_load = {in_tdata[31:0], 32'd0};
        cnt_load = CNT_W'(32);
      end
      default: begin
        val_load = in_tdata[63:0];
        cnt_load = CNT_W'(64);
      end
    endcase
  end

  // Drop leading zero digits until the top cell holds the first digit or only one digit is left.
  assign norm_go = (dchain[DIGITS] == 4'd0) && (norm_cnt_r != NORM_W'(DIGITS - 1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_CONV;
      end
      S_CONV: begin
        if (bit_cnt_r == CNT_W'(1)) state_nxt = S_NORM;
      end
      S_NORM: begin
        if (!norm_go) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_st.done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_tready  = 1'b0;
    emit_start = 1'b0;
    cell_op    = OP_HOLD;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cell_op   = OP_CLEAR;
      end
      S_CONV: cell_op = OP_DABBLE;
      S_NORM: begin
        cell_op    = norm_go ? OP_SHIFT : OP_HOLD;
        emit_start = !norm_go;
      end
      S_EMIT: cell_op = emit_st.dig_shift ? OP_SHIFT : OP_HOLD;
      default: cell_op = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Shift register, counters and captured format fields.
  always_ff @(posedge clk) begin
    if (accept) begin
      val_r      <= val_load;
      bit_cnt_r  <= cnt_load;
      norm_cnt_r <= '0;
      zero_val_r <= (val_load == '0);
      width_r    <= in_tdata[69:64];
      has_prec_r <= in_tdata[70];
      prec_r     <= in_tdata[76:71];
      zero_r     <= in_tdata[77];
      left_r     <= in_tdata[78];
    end else if (state_r == S_CONV) begin
      val_r     <= {val_r[VALUE_W-2:0], 1'b0};
      bit_cnt_r <= bit_cnt_r - CNT_W'(1);
    end else if ((state_r == S_NORM) && norm_go) begin
      norm_cnt_r <= norm_cnt_r + NORM_W'(1);
    end
  end

  // Digit count; zero with an explicit zero precision prints no digits.
  always_comb begin
    spec.ndig      = (has_prec_r && (prec_r == '0) && zero_val_r) ? '0
                   : DIG_W'(DIGITS) - DIG_W'(norm_cnt_r);
    spec.min_width = width_r;
    spec.has_prec  = has_prec_r;
    spec.prec      = prec_r;
    spec.zero_flag = zero_r;
    spec.left_flag = left_r;
  end

  // Chain of BCD digit cells, least significant digit first.
  assign carry[0]  = val_r[VALUE_W-1];
  assign dchain[0] = 4'd0;

  for (genvar k = 0; k < DIGITS; k++) begin : g_cell
    udf_bcd_cell u_cell (
      .clk      (clk),
      .op       (cell_op),
      .bit_in   (carry[k]),
      .digit_in (dchain[k]),
      .bit_out  (carry[k+1]),
      .digit    (dchain[k+1])
    );
  end

  udf_field_emit #(
    .MAX_FIELD (MAX_FIELD)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (emit_start),
    .spec       (spec),
    .top_digit  (dchain[DIGITS]),
    .status     (emit_st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Twenty digits hold any 64-bit value, so the top cell never carries out.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONV) |-> !carry[DIGITS])
    else $error("BCD chain overflow");

  // A new field is only started when the emitter is free.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit_start |-> !emit_st.busy)
    else $error("emitter started while busy");

  // Digits leave the chain only while a field is being emitted.
  a_shift_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit_st.dig_shift |-> (state_r == S_EMIT))
    else $error("digit shift outside emission");

  // An accepted beat always starts a conversion.
  a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_CONV))
    else $error("accepted beat did not start conversion");

endmodule
